### hdl/keyword_shift_substitution_cipher_defines.svh
// Assertion macros shared by the cipher RTL.
`ifndef KEYWORD_SHIFT_SUBSTITUTION_CIPHER_DEFINES_SVH
`define KEYWORD_SHIFT_SUBSTITUTION_CIPHER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KSSC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KSSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/kssc_pkg.sv
// Shared constants and types of the keyword substitution cipher.
`default_nettype none
package kssc_pkg;
	localparam int CHAR_W   = 8;
	localparam int SHIFT_W  = 5;
	localparam int MODE_W   = 2;
	localparam int STATUS_W = 2;

	localparam logic [MODE_W-1:0] MODE_KEY    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FINISH = 2'd1;
	localparam logic [MODE_W-1:0] MODE_ENCODE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_PASS      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_READY = 2'd2;
	localparam logic [STATUS_W-1:0] ST_REJECT    = 2'd3;

	localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

	// status of the shift reduction unit
	typedef struct packed {
		logic busy;
		logic done;
	} mod_stat_t;
endpackage
`default_nettype wire

### hdl/kssc_mod_unit.sv
// Iterative reduction of the shift distance modulo the alphabet size.
`default_nettype none
module kssc_mod_unit #(
	parameter int ALPHABET_SIZE = 26
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [kssc_pkg::SHIFT_W-1:0]  value,
	output kssc_pkg::mod_stat_t                stat,
	output logic [$clog2(ALPHABET_SIZE)-1:0]   result
);
	import kssc_pkg::*;

	localparam int IDX_W = $clog2(ALPHABET_SIZE);
	localparam logic [SHIFT_W:0] SIZE_EXT = (SHIFT_W+1)'(ALPHABET_SIZE);

	logic               busy_q;
	logic [SHIFT_W-1:0] rem_q;
	logic               fits;

	assign fits = ({1'b0, rem_q} < SIZE_EXT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && fits) begin
			busy_q <= 1'b0;
		end
	end

	// subtract one alphabet length per cycle until the remainder fits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= value;
		end else if (busy_q && !fits) begin
			rem_q <= SHIFT_W'({1'b0, rem_q} - SIZE_EXT);
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = busy_q && fits;
	assign result    = rem_q[IDX_W-1:0];
endmodule
`default_nettype wire

### hdl/keyword_shift_substitution_cipher.sv
// Keyword substitution cipher: key intake, table build and character encode.
// Results: key words, mode 3 and unmapped encodes load the output register on acceptance; a mapped encode via ST_ENC.
// Finish: iterative shift reduction (ST_MOD), a read and a write per kept key letter (ST_KRD,
//   ST_KWR), then one scan step per letter (ST_SCAN) over the shared cipher table write port.
// One transaction at a time; s_tready is low while an item is in flight or a result waits.
// Reset (arst_n, asynchronous) clears the key set, the ready flag and the shift register.
`default_nettype none
`include "keyword_shift_substitution_cipher_defines.svh"
module keyword_shift_substitution_cipher #(
	parameter int ALPHABET_SIZE = 26
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// slave stream: one key letter, finish request or plaintext character
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [15:0]                    s_tdata,   // [7:0] key_char, [15:8] in_char
	input  wire logic [kssc_pkg::MODE_W-1:0]    s_tuser,   // [1:0] mode
	// master stream: one result per transaction
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [kssc_pkg::CHAR_W-1:0]         m_tdata,   // [7:0] out_char
	output logic [kssc_pkg::STATUS_W-1:0]       m_tuser,   // [1:0] status
	// shift distance register write
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [kssc_pkg::SHIFT_W-1:0]   cfg_data
);
	import kssc_pkg::*;

	localparam int IDX_W = $clog2(ALPHABET_SIZE);
	localparam int CNT_W = $clog2(ALPHABET_SIZE + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ALPHABET_SIZE - 1);
	localparam logic [CNT_W-1:0] SIZE_CNT = CNT_W'(ALPHABET_SIZE);
	localparam logic [CHAR_W-1:0] CHAR_END = CHAR_W'(CHAR_A + ALPHABET_SIZE);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MOD  = 3'd1;
	localparam logic [2:0] ST_KRD  = 3'd2;
	localparam logic [2:0] ST_KWR  = 3'd3;
	localparam logic [2:0] ST_SCAN = 3'd4;
	localparam logic [2:0] ST_ENC  = 3'd5;

	logic [2:0]               state_q;
	logic [SHIFT_W-1:0]       shift_q;
	logic [ALPHABET_SIZE-1:0] used_q;
	logic [CNT_W-1:0]         count_q;
	logic                     ready_q;
	logic [IDX_W-1:0]         key_order_q [ALPHABET_SIZE];
	logic [IDX_W-1:0]         cipher_table_q [ALPHABET_SIZE];
	logic [IDX_W-1:0]         key_rd_q;
	logic [IDX_W-1:0]         cipher_rd_q;
	logic [CNT_W-1:0]         iter_q;
	logic [IDX_W-1:0]         scan_q;
	logic [IDX_W-1:0]         pos_q;
	logic [IDX_W-1:0]         dist_q;
	logic                     out_valid_q;
	logic [CHAR_W-1:0]        out_char_q;
	logic [STATUS_W-1:0]      out_status_q;

	// input field views
	logic [MODE_W-1:0] in_mode;
	logic [CHAR_W-1:0] key_char;
	logic [CHAR_W-1:0] in_char;
	logic              accept;
	logic [CHAR_W-1:0] key_off;
	logic [CHAR_W-1:0] in_off;
	logic              key_is_letter;
	logic              in_is_letter;
	logic [IDX_W-1:0]  key_idx;
	logic [IDX_W-1:0]  in_idx;

	// key intake
	logic [ALPHABET_SIZE-1:0] base_used;
	logic [CNT_W-1:0]         base_count;
	logic                     key_keep;

	// table build
	logic              mod_start;
	mod_stat_t         mod_stat;
	logic [IDX_W-1:0]  mod_result;
	logic              cipher_we;
	logic [IDX_W-1:0]  cipher_wdata;
	logic [IDX_W-1:0]  pos_next;
	logic              scan_last;

	// result load
	logic              load;
	logic [CHAR_W-1:0] load_char;
	logic [STATUS_W-1:0] load_status;

	assign in_mode  = s_tuser;
	assign key_char = s_tdata[7:0];
	assign in_char  = s_tdata[15:8];
	assign accept   = s_tvalid && s_tready;

	assign key_off       = key_char - CHAR_A;
	assign in_off        = in_char - CHAR_A;
	assign key_is_letter = (key_char >= CHAR_A) && (key_char < CHAR_END);
	assign in_is_letter  = (in_char >= CHAR_A) && (in_char < CHAR_END);
	assign key_idx       = key_off[IDX_W-1:0];
	assign in_idx        = in_off[IDX_W-1:0];

	// accept only when idle and the output register is free or draining
	assign s_tready  = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			shift_q <= cfg_data;
		end
	end

	// A key letter after a finished table starts a new key.
	assign base_used  = ready_q ? '0 : used_q;
	assign base_count = ready_q ? '0 : count_q;
	assign key_keep   = !base_used[key_idx] && (base_count < SIZE_CNT);

	kssc_mod_unit #(
		.ALPHABET_SIZE(ALPHABET_SIZE)
	) u_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mod_start),
		.value (shift_q),
		.stat  (mod_stat),
		.result(mod_result)
	);

	assign mod_start = accept && (in_mode == MODE_FINISH);
	assign pos_next  = (pos_q == LAST_IDX) ? '0 : pos_q + 1'b1;
	assign scan_last = (scan_q == LAST_IDX);

	// The rotated write position walks the table once: key letters first,
	// then every letter not in the key, in alphabet order.
	always_comb begin
		cipher_we    = 1'b0;
		cipher_wdata = key_rd_q;
		case (state_q)
			ST_KWR: begin
				cipher_we = 1'b1;
			end
			ST_SCAN: begin
				cipher_we    = !used_q[scan_q];
				cipher_wdata = scan_q;
			end
			default: begin
				cipher_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cipher_we) begin
			cipher_table_q[pos_q] <= cipher_wdata;
		end
		cipher_rd_q <= cipher_table_q[in_idx];
	end

	always_ff @(posedge clk) begin
		if (accept && (in_mode == MODE_KEY) && key_is_letter && key_keep) begin
			key_order_q[base_count[IDX_W-1:0]] <= key_idx;
		end
		key_rd_q <= key_order_q[iter_q[IDX_W-1:0]];
	end

	// sequencer and key state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			used_q  <= '0;
			count_q <= '0;
			ready_q <= 1'b0;
			iter_q  <= '0;
			scan_q  <= '0;
			pos_q   <= '0;
			dist_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (in_mode)
							MODE_KEY: begin
								if (key_is_letter) begin
									ready_q <= 1'b0;
									used_q  <= key_keep ?
										(base_used | (ALPHABET_SIZE'(1) << key_idx)) : base_used;
									count_q <= key_keep ? base_count + 1'b1 : base_count;
								end
							end
							MODE_FINISH: begin
								state_q <= ST_MOD;
							end
							MODE_ENCODE: begin
								if (ready_q && in_is_letter) begin
									state_q <= ST_ENC;
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_MOD: begin
					if (mod_stat.done) begin
						dist_q  <= mod_result;
						pos_q   <= mod_result;
						iter_q  <= '0;
						scan_q  <= '0;
						state_q <= (count_q == '0) ? ST_SCAN : ST_KRD;
					end
				end
				ST_KRD: begin
					state_q <= ST_KWR;
				end
				ST_KWR: begin
					pos_q   <= pos_next;
					iter_q  <= iter_q + 1'b1;
					state_q <= (iter_q + 1'b1 == count_q) ? ST_SCAN : ST_KRD;
				end
				ST_SCAN: begin
					if (!used_q[scan_q]) begin
						pos_q <= pos_next;
					end
					if (scan_last) begin
						ready_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				ST_ENC: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result selection
	always_comb begin
		load        = 1'b0;
		load_char   = '0;
		load_status = ST_OK;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (in_mode)
						MODE_KEY: begin
							load        = 1'b1;
							load_status = key_is_letter ? ST_OK : ST_REJECT;
						end
						MODE_ENCODE: begin
							if (!ready_q) begin
								load        = 1'b1;
								load_char   = in_char;
								load_status = ST_NOT_READY;
							end else if (!in_is_letter) begin
								load        = 1'b1;
								load_char   = in_char;
								load_status = (in_char == CHAR_SPACE) ? ST_OK : ST_PASS;
							end
						end
						MODE_FINISH: begin
							load = 1'b0;
						end
						default: begin
							load = 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				load = scan_last;
			end
			ST_ENC: begin
				load      = 1'b1;
				load_char = CHAR_A + CHAR_W'(cipher_rd_q);
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	// output register: hold until the sink takes the transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_char_q   <= load_char;
			out_status_q <= load_status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_char_q;
	assign m_tuser  = out_status_q;

	// one pass over the table leaves the write position back at the rotation
	`KSSC_ASSERT_NEXT(a_full_sweep, clk, arst_n, (state_q == ST_SCAN) && scan_last, pos_q == dist_q, "table build did not write every slot exactly once")
	// kept key letters and the used set must agree
	`KSSC_ASSERT_NOW(a_count_used, clk, arst_n, 1'b1, 32'(count_q) == $countones(used_q), "key count differs from used letter set")
	// a result never overwrites one the sink has not taken
	`KSSC_ASSERT_NOW(a_no_overrun, clk, arst_n, load && out_valid_q, m_tready, "result register overrun")
	// the reduction unit runs only while the sequencer waits for it
	`KSSC_ASSERT_NOW(a_mod_owner, clk, arst_n, mod_stat.busy, state_q == ST_MOD, "shift reduction busy outside its state")
endmodule
`default_nettype wire
